// File: sv/dsc_pkg.sv
// Package with the shared types and codes of the decimal-string syntax checker.
`default_nettype none
package dsc_pkg;

  localparam int CHAR_W   = 8;
  localparam int POS_W    = 7;
  localparam int PHASE_W  = 4;
  localparam int CAUSE_W  = 2;
  localparam int TDATA_IN_W  = 8;
  localparam int TDATA_OUT_W = 24;

  localparam logic [POS_W-1:0] MAX_LENGTH_RESET = 7'd16;
  localparam logic [POS_W-1:0] POS_SAT          = 7'd127;

  localparam logic [PHASE_W-1:0] PH_LEAD   = 4'd0;
  localparam logic [PHASE_W-1:0] PH_SIGNED = 4'd1;
  localparam logic [PHASE_W-1:0] PH_INT    = 4'd2;
  localparam logic [PHASE_W-1:0] PH_POINT  = 4'd3;
  localparam logic [PHASE_W-1:0] PH_FRAC   = 4'd4;
  localparam logic [PHASE_W-1:0] PH_EXP0   = 4'd5;
  localparam logic [PHASE_W-1:0] PH_EXPS   = 4'd6;
  localparam logic [PHASE_W-1:0] PH_EXPD   = 4'd7;
  localparam logic [PHASE_W-1:0] PH_TRAIL  = 4'd8;

  localparam logic [CAUSE_W-1:0] CAUSE_NONE     = 2'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_MANTISSA = 2'd1;
  localparam logic [CAUSE_W-1:0] CAUSE_EXPONENT = 2'd2;
  localparam logic [CAUSE_W-1:0] CAUSE_BAD_CHAR = 2'd3;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_E_UP  = 8'h45;
  localparam logic [CHAR_W-1:0] CH_E_LO  = 8'h65;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

  typedef struct packed {
    logic              kind;
    logic [CHAR_W-1:0] character;
  } item_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  bad_character;
    logic [POS_W-1:0]   bad_offset;
    logic               too_long;
    logic [CAUSE_W-1:0] cause;
    logic               valid_res;
  } res_t;

  function automatic logic [CAUSE_W-1:0] end_cause(input logic [PHASE_W-1:0] p);
    logic [CAUSE_W-1:0] c;
    case (p)
      PH_LEAD, PH_SIGNED, PH_POINT: c = CAUSE_MANTISSA;
      PH_EXP0, PH_EXPS:             c = CAUSE_EXPONENT;
      default:                      c = CAUSE_NONE;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// File: sv/dsc_in_stage.sv
// Input register of the checker, holding one accepted item until it is processed.
`default_nettype none
module dsc_in_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire dsc_pkg::item_t in_item,
  input  wire logic          out_ready,
  output logic               out_valid,
  output dsc_pkg::item_t     out_item
);

  logic           held_valid;
  dsc_pkg::item_t held_item;
  logic           advance;

  assign advance   = held_valid && out_ready;
  assign in_ready  = !held_valid || out_ready;
  assign out_valid = held_valid;
  assign out_item  = held_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule
`default_nettype wire

// File: sv/dsc_parser.sv
// Per-value syntax state and the verdict logic of the checker.
`default_nettype none
module dsc_parser (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       step,
  input  wire dsc_pkg::item_t             item,
  input  wire logic [dsc_pkg::POS_W-1:0]  max_length,
  output dsc_pkg::res_t                   result
);

  logic [dsc_pkg::PHASE_W-1:0] phase, phase_next;
  logic [dsc_pkg::POS_W-1:0]   position, position_next;
  logic                        overflow_seen, overflow_seen_next;
  logic                        decided, decided_next;
  logic [dsc_pkg::CAUSE_W-1:0] held_cause, held_cause_next;
  logic [dsc_pkg::POS_W-1:0]   held_offset, held_offset_next;
  logic [dsc_pkg::CHAR_W-1:0]  held_byte, held_byte_next;

  logic [dsc_pkg::CHAR_W-1:0]  ch;
  logic                        is_digit, is_sign, is_expo, is_space;
  logic                        past_limit;
  logic                        fix;
  logic [dsc_pkg::CAUSE_W-1:0] fix_cause;
  logic [dsc_pkg::PHASE_W-1:0] feed_phase;
  logic                        feed_fix;
  logic [dsc_pkg::CAUSE_W-1:0] feed_cause;
  logic [dsc_pkg::CAUSE_W-1:0] final_cause;

  assign ch         = item.character;
  assign is_digit   = (ch >= dsc_pkg::CH_ZERO) && (ch <= dsc_pkg::CH_NINE);
  assign is_sign    = (ch == dsc_pkg::CH_PLUS) || (ch == dsc_pkg::CH_MINUS);
  assign is_expo    = (ch == dsc_pkg::CH_E_UP) || (ch == dsc_pkg::CH_E_LO);
  assign is_space   = (ch == dsc_pkg::CH_SPACE);
  assign past_limit = (position >= max_length);

  always_comb begin
    feed_phase = phase;
    feed_fix   = 1'b0;
    feed_cause = dsc_pkg::CAUSE_NONE;
    case (phase)
      dsc_pkg::PH_LEAD: begin
        if (is_space) begin
          feed_phase = phase;
        end else if (is_sign) begin
          feed_phase = dsc_pkg::PH_SIGNED;
        end else if (is_digit) begin
          feed_phase = dsc_pkg::PH_INT;
        end else if (ch == dsc_pkg::CH_POINT) begin
          feed_phase = dsc_pkg::PH_POINT;
        end else begin
          feed_fix   = 1'b1;
          feed_cause = dsc_pkg::CAUSE_MANTISSA;
        end
      end
      dsc_pkg::PH_SIGNED: begin
        if (is_digit) begin
          feed_phase = dsc_pkg::PH_INT;
        end else if (ch == dsc_pkg::CH_POINT) begin
          feed_phase = dsc_pkg::PH_POINT;
        end else begin
          feed_fix   = 1'b1;
          feed_cause = dsc_pkg::CAUSE_MANTISSA;
        end
      end
      dsc_pkg::PH_INT: begin
        if (is_digit) begin
          feed_phase = phase;
        end else if (ch == dsc_pkg::CH_POINT) begin
          feed_phase = dsc_pkg::PH_FRAC;
        end else if (is_expo) begin
          feed_phase = dsc_pkg::PH_EXP0;
        end else if (is_space) begin
          feed_phase = dsc_pkg::PH_TRAIL;
        end else begin
          feed_fix   = 1'b1;
          feed_cause = dsc_pkg::CAUSE_BAD_CHAR;
        end
      end
      dsc_pkg::PH_POINT: begin
        if (is_digit) begin
          feed_phase = dsc_pkg::PH_FRAC;
        end else begin
          feed_fix   = 1'b1;
          feed_cause = dsc_pkg::CAUSE_MANTISSA;
        end
      end
      dsc_pkg::PH_FRAC: begin
        if (is_digit) begin
          feed_phase = phase;
        end else if (is_expo) begin
          feed_phase = dsc_pkg::PH_EXP0;
        end else if (is_space) begin
          feed_phase = dsc_pkg::PH_TRAIL;
        end else begin
          feed_fix   = 1'b1;
          feed_cause = dsc_pkg::CAUSE_BAD_CHAR;
        end
      end
      dsc_pkg::PH_EXP0: begin
        if (is_sign) begin
          feed_phase = dsc_pkg::PH_EXPS;
        end else if (is_digit) begin
          feed_phase = dsc_pkg::PH_EXPD;
        end else begin
          feed_fix   = 1'b1;
          feed_cause = dsc_pkg::CAUSE_EXPONENT;
        end
      end
      dsc_pkg::PH_EXPS: begin
        if (is_digit) begin
          feed_phase = dsc_pkg::PH_EXPD;
        end else begin
          feed_fix   = 1'b1;
          feed_cause = dsc_pkg::CAUSE_EXPONENT;
        end
      end
      dsc_pkg::PH_EXPD: begin
        if (is_digit) begin
          feed_phase = phase;
        end else if (is_space) begin
          feed_phase = dsc_pkg::PH_TRAIL;
        end else begin
          feed_fix   = 1'b1;
          feed_cause = dsc_pkg::CAUSE_BAD_CHAR;
        end
      end
      default: begin
        if (is_space) begin
          feed_phase = dsc_pkg::PH_TRAIL;
        end else begin
          feed_fix   = 1'b1;
          feed_cause = dsc_pkg::CAUSE_BAD_CHAR;
        end
      end
    endcase
  end

  always_comb begin
    if (past_limit || (ch == dsc_pkg::CH_NUL)) begin
      fix       = 1'b1;
      fix_cause = dsc_pkg::end_cause(phase);
    end else begin
      fix       = feed_fix;
      fix_cause = feed_cause;
    end
  end

  always_comb begin
    if (decided) begin
      final_cause = held_cause;
    end else if (position == '0) begin
      final_cause = dsc_pkg::CAUSE_NONE;
    end else begin
      final_cause = dsc_pkg::end_cause(phase);
    end
    result.valid_res = !overflow_seen && (final_cause == dsc_pkg::CAUSE_NONE);
    result.cause     = final_cause;
    result.too_long  = overflow_seen;
    if (final_cause == dsc_pkg::CAUSE_BAD_CHAR) begin
      result.bad_offset    = held_offset;
      result.bad_character = held_byte;
    end else begin
      result.bad_offset    = '0;
      result.bad_character = '0;
    end
  end

  always_comb begin
    phase_next         = phase;
    position_next      = position;
    overflow_seen_next = overflow_seen;
    decided_next       = decided;
    held_cause_next    = held_cause;
    held_offset_next   = held_offset;
    held_byte_next     = held_byte;
    if (step) begin
      if (item.kind == dsc_pkg::KIND_END) begin
        phase_next         = dsc_pkg::PH_LEAD;
        position_next      = '0;
        overflow_seen_next = 1'b0;
        decided_next       = 1'b0;
        held_cause_next    = dsc_pkg::CAUSE_NONE;
        held_offset_next   = '0;
        held_byte_next     = '0;
      end else begin
        if (!decided) begin
          if (fix) begin
            decided_next    = 1'b1;
            held_cause_next = fix_cause;
            if (fix_cause == dsc_pkg::CAUSE_BAD_CHAR) begin
              held_offset_next = position + 7'd1;
              held_byte_next   = ch;
            end
          end else begin
            phase_next = feed_phase;
          end
        end
        if (past_limit) begin
          overflow_seen_next = 1'b1;
        end
        if (position != dsc_pkg::POS_SAT) begin
          position_next = position + 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= dsc_pkg::PH_LEAD;
      position      <= '0;
      overflow_seen <= 1'b0;
      decided       <= 1'b0;
      held_cause    <= dsc_pkg::CAUSE_NONE;
      held_offset   <= '0;
      held_byte     <= '0;
    end else begin
      phase         <= phase_next;
      position      <= position_next;
      overflow_seen <= overflow_seen_next;
      decided       <= decided_next;
      held_cause    <= held_cause_next;
      held_offset   <= held_offset_next;
      held_byte     <= held_byte_next;
    end
  end

endmodule
`default_nettype wire

// File: sv/decimal_string_syntax_check_unit.sv
// Top level of the decimal-string syntax checker with configuration and result registers.
//
// Usage: the characters of one decimal-string value arrive on the slave stream, one per
// transfer, with tuser low; a transfer with tuser high ends the value. For each end
// transfer one verdict leaves on the master stream: valid flag, cause, over-length flag,
// and the offset and byte of the first unexpected character. Character transfers give
// no output.
// Timing: the input register holds an accepted end transfer, and the result register loads
// its verdict when the transfer leaves the input register.
// Throughput: one transfer per cycle while no end transfer waits for a pending verdict,
// set by the state update between the two registers.
// Stalls: while a verdict waits in the result register, character transfers keep
// flowing; a second end transfer waits in the input register until the verdict is taken.
// Reset (rst, synchronous): empties both registers, clears the per-value state and sets
// max_length to 16. cfg_wr_en writes max_length from cfg_wr_data at the clock edge; the
// user must assert it only while no value is in flight, which the block does not enforce.
`default_nettype none
module decimal_string_syntax_check_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_wr_en,
  input  wire logic [dsc_pkg::POS_W-1:0]          cfg_wr_data,    // max_length
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [dsc_pkg::TDATA_IN_W-1:0]     s_axis_tdata,   // [7:0] character
  input  wire logic                               s_axis_tuser,   // [0] kind
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [0] valid_res, [2:1] cause, [3] too_long, [10:4] bad_offset, [18:11] bad_character
  output logic [dsc_pkg::TDATA_OUT_W-1:0]         m_axis_tdata
);

  logic [dsc_pkg::POS_W-1:0] max_length;
  dsc_pkg::item_t            in_item;
  dsc_pkg::item_t            cur_item;
  logic                      cur_valid;
  logic                      cur_ready;
  logic                      step;
  dsc_pkg::res_t             result;
  dsc_pkg::res_t             out_res;
  logic                      out_valid;

  assign in_item.kind      = s_axis_tuser;
  assign in_item.character = s_axis_tdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= dsc_pkg::MAX_LENGTH_RESET;
    end else if (cfg_wr_en) begin
      max_length <= cfg_wr_data;
    end
  end

  dsc_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_item   (in_item),
    .out_ready (cur_ready),
    .out_valid (cur_valid),
    .out_item  (cur_item)
  );

  assign cur_ready = (cur_item.kind == dsc_pkg::KIND_CHAR) || !out_valid || m_axis_tready;
  assign step      = cur_valid && cur_ready;

  dsc_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .item       (cur_item),
    .max_length (max_length),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && (cur_item.kind == dsc_pkg::KIND_END)) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && (cur_item.kind == dsc_pkg::KIND_END)) begin
      out_res <= result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_res};

  a_valid_consistent: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[0] ==
                       ((m_axis_tdata[2:1] == dsc_pkg::CAUSE_NONE) && !m_axis_tdata[3])))
    else $error("valid_res disagrees with cause and too_long");

  a_offset_only_bad: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tdata[2:1] != dsc_pkg::CAUSE_BAD_CHAR)) |->
      (m_axis_tdata[18:4] == '0))
    else $error("bad offset or byte reported without an unexpected character");

  a_bad_offset_nonzero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tdata[2:1] == dsc_pkg::CAUSE_BAD_CHAR)) |->
      (m_axis_tdata[10:4] != '0))
    else $error("unexpected character reported at offset zero");

  a_ready_after_reset: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> (s_axis_tready && !m_axis_tvalid))
    else $error("block not empty after reset");

endmodule
`default_nettype wire
